### hdl/amgt_pkg.sv
package amgt_pkg;
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_EDGE  = 2'd1;
  localparam logic [1:0] OP_TRAV  = 2'd2;

  localparam logic [1:0] MODE_BFS = 2'd0;
  localparam logic [1:0] MODE_DFS = 2'd1;
  localparam logic [1:0] MODE_REC = 2'd2;

  localparam logic [0:0] REG_NUMV = 1'd0;
  localparam logic [0:0] REG_MODE = 1'd1;

  typedef struct packed {
    logic       clear;
    logic       add_edge;
    logic       load_start;
    logic       pop;
    logic       scan;
    logic       rec_step;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic       list_empty;
    logic       cand_any;
    logic       rec_empty;
    logic       clr_done;
  } sts_t;
endpackage

### hdl/amgt_ctrl.sv
module amgt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          go_i,
  input  logic [1:0]    op_i,
  input  logic          in_range_i,
  input  logic          b_in_range_i,
  input  logic [1:0]    mode_i,
  input  amgt_pkg::sts_t sts_i,
  input  logic          out_busy_i,
  output amgt_pkg::cmd_t cmd_o,
  output logic          idle_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_REC  = 3'd4;

  logic [2:0] state_q, state_d;

  // matrix is cleared row by row right after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLR;
    else state_q <= state_d;
  end

  assign idle_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (go_i) begin
          case (op_i)
            amgt_pkg::OP_CLEAR: begin
              cmd_o.clear = 1'b1;
              state_d = S_CLR;
            end
            amgt_pkg::OP_EDGE: cmd_o.add_edge = in_range_i && b_in_range_i;
            amgt_pkg::OP_TRAV: begin
              if (in_range_i) begin
                cmd_o.load_start = 1'b1;
                state_d = (mode_i == amgt_pkg::MODE_REC) ? S_REC : S_POP;
              end
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_POP: begin
        if (sts_i.list_empty) state_d = S_IDLE;
        else if (!out_busy_i) begin
          cmd_o.pop = 1'b1;
          cmd_o.emit = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (!sts_i.cand_any) state_d = S_POP;
      end
      S_REC: begin
        if (sts_i.rec_empty) state_d = S_IDLE;
        else if (!out_busy_i) begin
          cmd_o.rec_step = 1'b1;
          cmd_o.emit = sts_i.cand_any;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

### hdl/amgt_dp.sv
module amgt_dp #(
  parameter int MaxV = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  amgt_pkg::cmd_t  cmd_i,
  input  logic [1:0]      mode_i,
  input  logic [4:0]      numv_i,
  input  logic [3:0]      va_i,
  input  logic [3:0]      vb_i,
  output logic            in_range_o,
  output logic            b_in_range_o,
  output amgt_pkg::sts_t  sts_o,
  output logic            emit_o,
  output logic [3:0]      emit_v_o
);
  localparam int IW = $clog2(MaxV);
  localparam int CW = $clog2(MaxV + 1);
  localparam int KW = (CW >= 4) ? CW + 1 : 5;

  logic [MaxV-1:0] adj_q [MaxV];
  logic [MaxV-1:0] vis_q;
  logic [IW-1:0]   wl_q [MaxV];
  logic [IW-1:0]   rf_q [MaxV];
  logic [CW-1:0]   head_q, tail_q;
  logic [MaxV-1:0] cand_q;
  logic [IW-1:0]   clr_q;
  logic            stack_q;

  logic [KW-1:0]   n_ext;
  logic [KW-1:0]   n_act;
  logic [MaxV-1:0] act;
  logic [IW-1:0]   a_ix, b_ix, pop_v, top_v, low_ix, rlow_ix;
  logic [MaxV-1:0] rec_cand, scan_src;

  assign n_ext = KW'(numv_i);
  assign n_act = (n_ext > KW'(MaxV)) ? KW'(MaxV) : n_ext;
  always_comb begin
    for (int i = 0; i < MaxV; i++) act[i] = (KW'(i) < n_act);
  end
  assign a_ix = IW'(va_i);
  assign b_ix = IW'(vb_i);
  assign in_range_o   = (KW'(va_i) < n_act);
  assign b_in_range_o = (KW'(vb_i) < n_act);

  assign pop_v = stack_q ? wl_q[IW'(tail_q - 1'b1)] : wl_q[IW'(head_q)];
  assign top_v = rf_q[IW'(tail_q - 1'b1)];
  assign rec_cand = adj_q[top_v] & act & ~vis_q;
  assign scan_src = cand_q;

  always_comb begin
    low_ix = '0;
    for (int i = MaxV - 1; i >= 0; i--) if (scan_src[i]) low_ix = IW'(i);
  end
  always_comb begin
    rlow_ix = '0;
    for (int i = MaxV - 1; i >= 0; i--) if (rec_cand[i]) rlow_ix = IW'(i);
  end

  assign sts_o.list_empty = stack_q ? (tail_q == '0) : (head_q == tail_q);
  assign sts_o.cand_any   = (mode_i == amgt_pkg::MODE_REC) ?
                            ((rec_cand != '0) && (tail_q < CW'(MaxV))) :
                            (cand_q != '0);
  assign sts_o.rec_empty  = (tail_q == '0);
  assign sts_o.clr_done   = (clr_q == IW'(MaxV - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) adj_q[clr_q] <= '0;
    else if (cmd_i.add_edge) begin
      adj_q[a_ix][b_ix] <= 1'b1;
      adj_q[b_ix][a_ix] <= 1'b1;
    end
    if (cmd_i.load_start) begin
      wl_q[0] <= a_ix;
      rf_q[0] <= a_ix;
    end
    if (cmd_i.scan && cand_q != '0 && tail_q < CW'(MaxV)) wl_q[IW'(tail_q)] <= low_ix;
    if (cmd_i.rec_step && sts_o.cand_any) rf_q[IW'(tail_q)] <= rlow_ix;
    if (cmd_i.pop) cand_q <= adj_q[pop_v] & act & ~vis_q;
    else if (cmd_i.scan) cand_q <= cand_q & (cand_q - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_q <= '0; head_q <= '0; tail_q <= '0; clr_q <= '0; stack_q <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_q <= (clr_q == IW'(MaxV - 1)) ? '0 : clr_q + 1'b1;
      if (cmd_i.load_start) begin
        vis_q <= MaxV'(1) << a_ix;
        head_q <= '0;
        tail_q <= CW'(1);
        stack_q <= (mode_i == amgt_pkg::MODE_DFS);
      end else if (cmd_i.pop) begin
        if (stack_q) tail_q <= tail_q - 1'b1;
        else head_q <= head_q + 1'b1;
      end else if (cmd_i.scan && cand_q != '0) begin
        vis_q[low_ix] <= 1'b1;
        if (tail_q < CW'(MaxV)) tail_q <= tail_q + 1'b1;
      end else if (cmd_i.rec_step) begin
        if (sts_o.cand_any) begin
          vis_q[rlow_ix] <= 1'b1;
          tail_q <= tail_q + 1'b1;
        end else tail_q <= tail_q - 1'b1;
      end
    end
  end

  assign emit_o = cmd_i.emit || (cmd_i.load_start && mode_i == amgt_pkg::MODE_REC);
  assign emit_v_o = cmd_i.load_start ? va_i :
                    (cmd_i.rec_step ? 4'(rlow_ix) : 4'(pop_v));
endmodule

### hdl/adjacency_matrix_graph_traversal_core.sv
// Graph traversal over an undirected adjacency bit matrix of MAX_VERTICES vertices. Register
// 0 (address 0) holds the active vertex count, register 1 (address 4) the mode: breadth-first,
// explicit-stack depth-first or recursive-order depth-first. An input transfer clears the
// matrix, adds an edge or starts a traversal; a traversal sends one output transfer per visited
// vertex, tlast on the final one, and out-of-range vertices or op 3 produce nothing. After
// reset the matrix is cleared one row per cycle before tready rises, and a clear works the
// same way. Queue and stack traversals load the start vertex, then for each visited vertex
// pop it and scan its row, pushing each newly found neighbor in turn with the single
// find-first row scanner and leaving the scan once none is left; they end when the list is
// found empty. Recursive order loads the start vertex, then at each step either enters the
// lowest unvisited neighbor of the vertex on top of the stack or returns from it, and ends
// when the stack is found empty. Each result waits in a pending register until the next one or
// the end of the run fixes tlast, then moves to the output register; the traversal stalls
// while both are full and the sink is not ready, and tready stays low until the last
// result has been transferred.
module adjacency_matrix_graph_traversal_core #(
  parameter int MAX_VERTICES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i, // op[1:0], vertex_a[5:2], vertex_b[9:6]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o, // visited_vertex[3:0]
  output logic        m_axis_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [4:0] numv_q;
  logic [1:0] mode_q;
  amgt_pkg::cmd_t cmd;
  amgt_pkg::sts_t sts;
  logic idle, in_range, b_in_range, emit, go;
  logic [3:0] emit_v;
  logic       pend_q;
  logic [3:0] pend_v_q;
  logic       ov_q, olast_q;
  logic [3:0] ovx_q;
  logic       pend_fire;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      numv_q <= 5'd16; mode_q <= amgt_pkg::MODE_BFS;
    end else if (psel && penable && pwrite) begin
      if (paddr == {amgt_pkg::REG_NUMV, 2'b00}) numv_q <= pwdata[4:0];
      else if (paddr == {amgt_pkg::REG_MODE, 2'b00}) mode_q <= pwdata[1:0];
    end
  end
  assign prdata = (paddr == {amgt_pkg::REG_NUMV, 2'b00}) ? {27'd0, numv_q} :
                  (paddr == {amgt_pkg::REG_MODE, 2'b00}) ? {30'd0, mode_q} : 32'd0;

  assign s_axis_tready_o = idle && !pend_q && !ov_q;
  assign go = s_axis_tvalid_i && s_axis_tready_o;

  amgt_ctrl u_ctrl (
    .clk_i, .rst_ni, .go_i(go), .op_i(s_axis_tdata_i[1:0]), .in_range_i(in_range),
    .b_in_range_i(b_in_range), .mode_i(mode_q), .sts_i(sts),
    .out_busy_i(pend_q && ov_q && !m_axis_tready_i), .cmd_o(cmd), .idle_o(idle)
  );

  amgt_dp #(.MaxV(MAX_VERTICES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .mode_i(mode_q), .numv_i(numv_q),
    .va_i(s_axis_tdata_i[5:2]), .vb_i(s_axis_tdata_i[9:6]), .in_range_o(in_range),
    .b_in_range_o(b_in_range), .sts_o(sts), .emit_o(emit), .emit_v_o(emit_v)
  );

  assign pend_fire = pend_q && (!ov_q || m_axis_tready_i) && (emit || idle);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0; ov_q <= 1'b0; pend_v_q <= '0; ovx_q <= '0; olast_q <= 1'b0;
    end else begin
      if (pend_fire) begin
        ov_q <= 1'b1; ovx_q <= pend_v_q; olast_q <= !emit;
      end else if (ov_q && m_axis_tready_i) ov_q <= 1'b0;
      if (emit) begin
        pend_q <= 1'b1; pend_v_q <= emit_v;
      end else if (pend_fire) pend_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o = {4'd0, ovx_q};
  assign m_axis_tlast_o = olast_q;
endmodule
